/* src/sdiv_pkg.sv */
// Shared types and constants for the signed restoring divider.
package sdiv_pkg;

  localparam int DATA_WIDTH = 32;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] dividend;
    logic signed [DATA_WIDTH-1:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quotient;
    logic                         divide_by_zero;
    logic                         overflow;
  } out_item_t;

  // Work carried from one cell of the chain to the next.
  typedef struct packed {
    logic                  neg;
    logic                  dz;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] dvs;
    logic [DATA_WIDTH-1:0] qmag;
  } stage_t;

endpackage

/* src/signed_restoring_divider.sv */
// Top level of the signed restoring divider: front register, cell chain and result register.
//
// Usage: an item on in_item carries a signed dividend and divisor; the result item on
// out_item carries the quotient truncated toward zero, a divide-by-zero flag and an
// overflow flag. Both channels use valid/ready.
// On acceptance the operand magnitudes and signs are registered. The item then walks
// a row of 32 identical cells, one per quotient bit from the highest down, one cell per
// cycle while the chain does not stall. The last step fixes the sign and loads the
// result register. One item is in flight in the chain at a time, so a new item is
// accepted in the cycle after the previous one leaves the chain. The result register
// lets the next item start while the previous result waits. When the receiver stalls
// and the result register is full, a finished item waits in the last cell and in_ready
// stays low.
// Divide by zero gives quotient 0 with divide_by_zero set; the most negative value
// divided by minus one wraps and sets overflow.
// Reset (rst, synchronous) empties the chain and the result register.
module signed_restoring_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdiv_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sdiv_pkg::out_item_t out_item
);

  localparam int W = sdiv_pkg::DATA_WIDTH;

  logic             valid [0:W];
  sdiv_pkg::stage_t stage [0:W];
  logic [W:0]       valid_vec;
  logic             advance;
  logic             in_fire;
  logic             load_out;
  sdiv_pkg::stage_t front_next;
  sdiv_pkg::out_item_t out_next;

  assign in_fire  = in_valid && in_ready;
  assign load_out = valid[W] && (!out_valid || out_ready);
  // The chain only stalls when a finished item cannot enter the result register.
  assign advance  = !(valid[W] && out_valid && !out_ready);

  always_comb begin
    for (int k = 0; k <= W; k++) begin
      valid_vec[k] = valid[k];
    end
  end

  assign in_ready = !(|valid_vec);

  always_comb begin
    front_next.neg  = in_item.dividend[W-1] ^ in_item.divisor[W-1];
    front_next.dz   = (in_item.divisor == '0);
    front_next.rem  = in_item.dividend[W-1] ? (W'(0) - W'(in_item.dividend))
                                            : W'(in_item.dividend);
    front_next.dvs  = in_item.divisor[W-1] ? (W'(0) - W'(in_item.divisor))
                                           : W'(in_item.divisor);
    front_next.qmag = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (in_fire) begin
      valid[0] <= 1'b1;
    end else if (advance) begin
      valid[0] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage[0] <= front_next;
    end
  end

  // Cell k settles quotient bit W-1-k.
  for (genvar k = 0; k < W; k++) begin : g_cell
    sdiv_cell #(
      .BIT(W - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .prev_valid(valid[k]),
      .prev_stage(stage[k]),
      .valid     (valid[k+1]),
      .stage     (stage[k+1])
    );
  end

  always_comb begin
    out_next.divide_by_zero = stage[W].dz;
    if (stage[W].dz) begin
      out_next.quotient = '0;
      out_next.overflow = 1'b0;
    end else begin
      out_next.quotient = stage[W].neg ? (W'(0) - stage[W].qmag) : stage[W].qmag;
      out_next.overflow = !stage[W].neg && stage[W].qmag[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item <= out_next;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0(valid_vec))
    else $error("more than one item in the divider chain");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted while an item is still in the chain");

  a_dz_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.divide_by_zero |-> out_item.quotient == '0 && !out_item.overflow)
    else $error("divide by zero result carries a quotient or overflow");

  a_ovf_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.overflow |-> out_item.quotient == {1'b1, {(W-1){1'b0}}})
    else $error("overflow result is not the most negative value");

endmodule

/* src/sdiv_cell.sv */
// One cell of the divider chain: settles a single quotient bit and registers the work.
module sdiv_cell #(
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            prev_valid,
  input  sdiv_pkg::stage_t prev_stage,
  output logic            valid,
  output sdiv_pkg::stage_t stage
);

  localparam int W = sdiv_pkg::DATA_WIDTH;

  sdiv_pkg::stage_t stage_next;
  logic             fits;

  // The shifted divisor fits exactly when the remainder shifted down covers the divisor.
  assign fits = (prev_stage.rem >> BIT) >= prev_stage.dvs;

  always_comb begin
    stage_next = prev_stage;
    if (fits) begin
      stage_next.rem  = prev_stage.rem - (prev_stage.dvs << BIT);
      stage_next.qmag = prev_stage.qmag | (W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage <= stage_next;
    end
  end

endmodule
